// ----- hw/rtl/stc_pkg.sv -----
// Shared types, constants and register codes for the scope trigger capture block.
`default_nettype none

package stc_pkg;

    // Ring and sample geometry
    localparam int DEPTH = 1024;
    localparam int AW    = 10;
    localparam int SW    = 16;
    localparam int PHW   = 22;
    localparam int PW    = 20;
    localparam int LW    = 11;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 20;

    // Opcodes of an input item
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Trigger modes (any other code behaves as fixed threshold)
    localparam logic [1:0] MODE_FREE  = 2'd0;
    localparam logic [1:0] MODE_AUTO  = 2'd1;
    localparam logic [1:0] MODE_FIXED = 2'd2;

    // Register indexes
    localparam logic [CFG_IW-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IW-1:0] REG_THRESHOLD = 3'd1;
    localparam logic [CFG_IW-1:0] REG_PERIOD    = 3'd2;
    localparam logic [CFG_IW-1:0] REG_LENGTH    = 3'd3;
    localparam logic [CFG_IW-1:0] REG_PRETRIG   = 3'd4;
    localparam logic [CFG_IW-1:0] REG_LEVELS    = 3'd5;

    // Register reset values
    localparam logic [1:0]           RST_MODE      = MODE_AUTO;
    localparam logic signed [SW-1:0] RST_THRESHOLD = 16'sd16384;
    localparam logic [PW-1:0]        RST_PERIOD    = 20'd4410;
    localparam logic [LW-1:0]        RST_LENGTH    = 11'd128;
    localparam logic [AW-1:0]        RST_PRETRIG   = 10'd0;
    localparam logic [LW-1:0]        RST_LEVELS    = 11'd128;

    // Most negative sample
    localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef enum logic [1:0] {
        EV_CAPTURE_READY = 2'd0,
        EV_NO_TRIGGER    = 2'd1,
        EV_DISPLAY       = 2'd2,
        EV_NOTHING       = 2'd3
    } t_event;

    typedef struct packed {
        logic                 opcode;
        logic signed [SW-1:0] sample;
        logic [AW-1:0]        read_position;
    } t_in_item;

    typedef struct packed {
        t_event        event_code;
        logic [AW-1:0] start_position;
        logic [AW-1:0] display_value;
    } t_out_item;

    typedef struct packed {
        logic [1:0]           mode;
        logic signed [SW-1:0] threshold;
        logic [PW-1:0]        period;
        logic [LW-1:0]        length;
        logic [AW-1:0]        pretrig;
        logic [LW-1:0]        levels;
    } t_cfg;

    // Trigger unit outcome for one push item
    typedef struct packed {
        logic          fire;
        t_event        code;
        logic [AW-1:0] start;
    } t_trig_res;

endpackage

`default_nettype wire

// ----- hw/rtl/stc_ring.sv -----
// Sample ring memory with registered read and a fill count standing in for the zero clear.
`default_nettype none

module stc_ring (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_we,
    input  wire logic [stc_pkg::AW-1:0]       i_waddr,
    input  wire logic signed [stc_pkg::SW-1:0] i_wdata,
    input  wire logic                         i_re,
    input  wire logic [stc_pkg::AW-1:0]       i_raddr,
    output logic signed [stc_pkg::SW-1:0]     o_rdata
);
    import stc_pkg::*;

    logic signed [SW-1:0] r_mem [DEPTH];
    logic signed [SW-1:0] r_rdata;
    logic                 r_rd_written;
    logic [AW:0]          r_fill;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // Count entries written since reset; writes go in ring order from entry zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_we && (r_fill != (AW+1)'(DEPTH))) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_re) begin
                r_rd_written <= ({1'b0, i_raddr} < r_fill);
            end
        end
    end

    // Entries never written read as zero
    assign o_rdata = r_rd_written ? r_rdata : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/stc_trigger.sv -----
// Trigger state: phase counter, peak tracking, live threshold and capture window.
`default_nettype none

module stc_trigger (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire logic signed [stc_pkg::SW-1:0] i_sample,
    input  wire stc_pkg::t_cfg                 i_cfg,
    input  wire logic                          i_cfg_clear,
    input  wire logic                          i_thr_load,
    input  wire logic signed [stc_pkg::SW-1:0] i_thr_value,
    output logic [stc_pkg::AW-1:0]             o_write_position,
    output logic [stc_pkg::AW-1:0]             o_capture_start,
    output logic                               o_capture_valid,
    output stc_pkg::t_trig_res                 o_res
);
    import stc_pkg::*;

    logic signed [PHW-1:0] r_phase, n_phase;
    logic signed [SW-1:0]  r_peak, n_peak;
    logic signed [SW-1:0]  r_last, n_last;
    logic signed [SW-1:0]  r_thr, n_thr;
    logic [AW-1:0]         r_wp;
    logic [AW-1:0]         r_start, n_start;
    logic                  r_cv, n_cv;

    logic [LW-1:0]         len;
    logic [AW-1:0]         len_m1;
    logic [AW-1:0]         pre;
    logic [PW-1:0]         period_eff;
    logic signed [PHW-1:0] ph_period;
    logic signed [PHW-1:0] ph_len;
    logic signed [SW+2:0]  pk_ext;
    logic signed [SW+2:0]  tq_sum;
    logic signed [SW-1:0]  tq;
    logic signed [SW-1:0]  peak_base;
    logic                  auto_mode;
    logic                  trig;
    t_trig_res             res;

    // Saturate length, pretrigger and period
    always_comb begin
        if (i_cfg.length == '0) begin
            len = LW'(1);
        end else if (i_cfg.length > LW'(DEPTH)) begin
            len = LW'(DEPTH);
        end else begin
            len = i_cfg.length;
        end
        len_m1     = AW'(len - 1'b1);
        pre        = (i_cfg.pretrig > len_m1) ? len_m1 : i_cfg.pretrig;
        period_eff = (i_cfg.period < PW'(len)) ? PW'(len) : i_cfg.period;
        ph_period  = $signed(PHW'(period_eff));
        ph_len     = $signed(PHW'(len));
    end

    // Three quarters of the peak, rounded up
    always_comb begin
        pk_ext = {{3{r_peak[SW-1]}}, r_peak};
        tq_sum = pk_ext + (pk_ext <<< 1) + (SW+3)'(3);
        tq     = tq_sum[SW+1:2];
    end

    assign auto_mode = (i_cfg.mode == MODE_AUTO);
    assign trig      = (r_last <= i_sample) && (i_sample >= r_thr);

    // Next state for one push item
    always_comb begin
        n_phase    = r_phase;
        n_peak     = r_peak;
        n_last     = r_last;
        n_thr      = r_thr;
        n_start    = r_start;
        n_cv       = r_cv;
        peak_base  = r_peak;
        res.fire   = 1'b0;
        res.code   = EV_CAPTURE_READY;
        if (i_cfg.mode == MODE_FREE) begin
            if (r_phase >= ph_period) begin
                n_phase = PHW'(1);
                n_start = r_wp;
                n_peak  = SAMPLE_MIN;
            end else begin
                if (r_phase == ph_len) begin
                    n_cv     = 1'b1;
                    res.fire = 1'b1;
                    res.code = EV_CAPTURE_READY;
                end
                n_phase = r_phase + 1'b1;
            end
        end else begin
            if (r_phase <= $signed(PHW'(0))) begin
                if (trig) begin
                    n_start = r_wp - pre;
                    n_phase = $signed(PHW'(pre) + PHW'(1));
                end else if (r_phase <= -ph_period) begin
                    n_phase   = -PHW'(1);
                    n_cv      = 1'b0;
                    res.fire  = 1'b1;
                    res.code  = EV_NO_TRIGGER;
                    peak_base = SAMPLE_MIN;
                    if (auto_mode) begin
                        n_thr = tq;
                    end
                end else begin
                    n_phase = r_phase - 1'b1;
                end
            end else if (r_phase >= ph_period) begin
                peak_base = SAMPLE_MIN;
                n_phase   = -PHW'(1);
                if (auto_mode) begin
                    n_thr = tq;
                end
            end else begin
                if (r_phase == ph_len) begin
                    n_cv     = 1'b1;
                    res.fire = 1'b1;
                    res.code = EV_CAPTURE_READY;
                end
                n_phase = r_phase + 1'b1;
            end
            n_peak = (i_sample > peak_base) ? i_sample : peak_base;
            n_last = i_sample;
        end
        res.start = n_start;
    end

    // Hold trigger state; a configuration write restarts the run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_peak  <= SAMPLE_MIN;
            r_last  <= '0;
            r_thr   <= RST_THRESHOLD;
            r_wp    <= '0;
            r_start <= '0;
            r_cv    <= 1'b0;
        end else if (i_cfg_clear) begin
            r_phase <= '0;
            r_peak  <= SAMPLE_MIN;
            r_cv    <= 1'b0;
            if (i_thr_load) begin
                r_thr <= i_thr_value;
            end
        end else if (i_push) begin
            r_phase <= n_phase;
            r_peak  <= n_peak;
            r_last  <= n_last;
            r_thr   <= n_thr;
            r_start <= n_start;
            r_cv    <= n_cv;
            r_wp    <= r_wp + 1'b1;
        end
    end

    assign o_write_position = r_wp;
    assign o_capture_start  = r_start;
    assign o_capture_valid  = r_cv;
    assign o_res            = res;

endmodule

`default_nettype wire

// ----- hw/rtl/stc_display.sv -----
// Map a captured sample to a clamped display level.
`default_nettype none

module stc_display (
    input  wire logic signed [stc_pkg::SW-1:0] i_sample,
    input  wire logic [stc_pkg::LW-1:0]        i_levels,
    output logic [stc_pkg::AW-1:0]             o_level
);
    import stc_pkg::*;

    localparam int PRW = AW + SW;

    logic [LW-1:0]  lv;
    logic [AW-1:0]  lv_m1;
    logic [SW-1:0]  offset;
    logic [PRW:0]   scaled;
    logic [LW-1:0]  level;

    // Saturate levels, scale offset-binary sample and round
    always_comb begin
        if (i_levels == '0) begin
            lv = LW'(1);
        end else if (i_levels > LW'(1024)) begin
            lv = LW'(1024);
        end else begin
            lv = i_levels;
        end
        lv_m1  = AW'(lv - 1'b1);
        offset = {~i_sample[SW-1], i_sample[SW-2:0]};
        scaled = (PRW+1)'(lv_m1) * (PRW+1)'(offset) + (PRW+1)'(1 << (SW-1));
        level  = LW'(scaled[PRW:SW]);
        o_level = (level > LW'(lv_m1)) ? lv_m1 : AW'(level);
    end

endmodule

`default_nettype wire

// ----- hw/rtl/scope_trigger_capture_top.sv -----
// Top level of the scope trigger capture block: registers, item pipeline and output stage.
//
// Input channel (i_in_valid / o_in_ready) carries one item: a push of one sample into
// the 1024-entry ring, or a read of one position of the captured trace. Output channel
// (o_out_valid / i_out_ready) carries at most one result item per input item: capture
// ready, period without trigger, display value, or nothing captured.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data); any write to a
// known register restarts the trigger run and drops the current capture.
// Throughput: one item per cycle while the receiver takes results. An item passes through
// two register stages: the ring read and middle stage, then the output register fed by
// the display mapping, where the result waits until the receiver takes it.
// When the receiver stalls, the output register holds its result and the middle stage
// still takes one more item; the input stalls only when both are full.
// Reset restores the register defaults and empties the pipeline. The ring is not swept:
// a fill count makes entries not yet written read as zero, so the block is ready for
// items as soon as reset is released.
`default_nettype none

module scope_trigger_capture_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire stc_pkg::t_in_item              i_in_item,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output stc_pkg::t_out_item                  o_out_item,
    input  wire logic                           i_cfg_we,
    input  wire logic [stc_pkg::CFG_IW-1:0]     i_cfg_index,
    input  wire logic [stc_pkg::CFG_DW-1:0]     i_cfg_data
);
    import stc_pkg::*;

    t_cfg                 r_cfg;
    logic                 cfg_hit;
    logic                 thr_load;
    logic                 accept;
    logic                 push;
    logic                 rd;
    logic [AW-1:0]        wp;
    logic [AW-1:0]        cap_start;
    logic                 cap_valid;
    t_trig_res            trig_res;
    logic signed [SW-1:0] rd_sample;
    logic [AW-1:0]        disp_level;

    logic                 r_s1_valid;
    logic                 r_s1_disp;
    t_out_item            r_s1_item;
    logic                 s1_adv;
    logic                 r_out_valid;
    t_out_item            r_out_item;

    // Configuration register file
    assign cfg_hit  = i_cfg_we && (i_cfg_index <= REG_LEVELS);
    assign thr_load = i_cfg_we && (i_cfg_index == REG_THRESHOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= RST_MODE;
            r_cfg.threshold <= RST_THRESHOLD;
            r_cfg.period    <= RST_PERIOD;
            r_cfg.length    <= RST_LENGTH;
            r_cfg.pretrig   <= RST_PRETRIG;
            r_cfg.levels    <= RST_LEVELS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MODE:      r_cfg.mode      <= i_cfg_data[1:0];
                REG_THRESHOLD: r_cfg.threshold <= $signed(i_cfg_data[SW-1:0]);
                REG_PERIOD:    r_cfg.period    <= i_cfg_data[PW-1:0];
                REG_LENGTH:    r_cfg.length    <= i_cfg_data[LW-1:0];
                REG_PRETRIG:   r_cfg.pretrig   <= i_cfg_data[AW-1:0];
                REG_LEVELS:    r_cfg.levels    <= i_cfg_data[LW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Item acceptance
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;
    assign push       = accept && (i_in_item.opcode == OP_PUSH);
    assign rd         = accept && (i_in_item.opcode == OP_READ);

    stc_trigger u_trigger (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_sample         (i_in_item.sample),
        .i_cfg            (r_cfg),
        .i_cfg_clear      (cfg_hit),
        .i_thr_load       (thr_load),
        .i_thr_value      ($signed(i_cfg_data[SW-1:0])),
        .o_write_position (wp),
        .o_capture_start  (cap_start),
        .o_capture_valid  (cap_valid),
        .o_res            (trig_res)
    );

    stc_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (push),
        .i_waddr (wp),
        .i_wdata (i_in_item.sample),
        .i_re    (rd),
        .i_raddr (cap_start + i_in_item.read_position),
        .o_rdata (rd_sample)
    );

    stc_display u_display (
        .i_sample (rd_sample),
        .i_levels (r_cfg.levels),
        .o_level  (disp_level)
    );

    // Middle stage: hold the item while the ring read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= rd || trig_res.fire;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item.display_value <= '0;
            if (rd) begin
                r_s1_disp                <= cap_valid;
                r_s1_item.event_code     <= cap_valid ? EV_DISPLAY : EV_NOTHING;
                r_s1_item.start_position <= cap_start;
            end else begin
                r_s1_disp                <= 1'b0;
                r_s1_item.event_code     <= trig_res.code;
                r_s1_item.start_position <= trig_res.start;
            end
        end
    end

    // Output register: load from the middle stage, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_item.event_code     <= r_s1_item.event_code;
            r_out_item.start_position <= r_s1_item.start_position;
            r_out_item.display_value  <= r_s1_disp ? disp_level : r_s1_item.display_value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire
